@@ hdl/smfp_pkg.sv @@
// ----------------------------------------------------------------------------
// smfp_pkg
// Types and constants shared by the stack map frame parser modules.
// ----------------------------------------------------------------------------
package smfp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_CNT_LO  = 4'd1,
		PH_TYPE    = 4'd2,
		PH_OFF_HI  = 4'd3,
		PH_OFF_LO  = 4'd4,
		PH_NLOC_HI = 4'd5,
		PH_NLOC_LO = 4'd6,
		PH_NSTK_HI = 4'd7,
		PH_NSTK_LO = 4'd8,
		PH_LTAG    = 4'd9,
		PH_LVAL_HI = 4'd10,
		PH_LVAL_LO = 4'd11,
		PH_STAG    = 4'd12,
		PH_SVAL_HI = 4'd13,
		PH_SVAL_LO = 4'd14
	} phase_t;

	// token kinds
	localparam logic [2:0] TK_HEADER = 3'd0;
	localparam logic [2:0] TK_LCOUNT = 3'd1;
	localparam logic [2:0] TK_SCOUNT = 3'd2;
	localparam logic [2:0] TK_ENTRY  = 3'd3;
	localparam logic [2:0] TK_EMPTY  = 3'd4;
	localparam logic [2:0] TK_ERROR  = 3'd5;

	// frame forms
	localparam logic [2:0] FF_SAME     = 3'd0;
	localparam logic [2:0] FF_ONE_STK  = 3'd1;
	localparam logic [2:0] FF_ONE_EXT  = 3'd2;
	localparam logic [2:0] FF_CHOP     = 3'd3;
	localparam logic [2:0] FF_SAME_EXT = 3'd4;
	localparam logic [2:0] FF_APPEND   = 3'd5;
	localparam logic [2:0] FF_FULL     = 3'd6;
	localparam logic [2:0] FF_RESERVED = 3'd7;

	// frame type byte boundaries
	localparam logic [7:0] FT_SAME_MAX     = 8'd63;
	localparam logic [7:0] FT_ONE_STK_MAX  = 8'd127;
	localparam logic [7:0] FT_RESERVED_MAX = 8'd246;
	localparam logic [7:0] FT_ONE_EXT      = 8'd247;
	localparam logic [7:0] FT_CHOP_MAX     = 8'd250;
	localparam logic [7:0] FT_SAME_EXT     = 8'd251;
	localparam logic [7:0] FT_APPEND_MAX   = 8'd254;
	localparam logic [7:0] FT_FULL         = 8'd255;

	// verification tags
	localparam logic [7:0] VT_OBJECT   = 8'd7;
	localparam logic [7:0] VT_UNINIT   = 8'd8;
	localparam logic [7:0] VT_MAX      = 8'd8;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] frames_left;
		logic [15:0] frame_index;
		logic [7:0]  held_type;
		logic [15:0] held_offset;
		logic [15:0] locals_left;
		logic [15:0] stack_left;
		logic [15:0] list_position;
		logic [7:0]  held_tag;
		logic [7:0]  high_byte;
	} state_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] frame_number;
		logic [7:0]  frame_type_byte;
		logic [2:0]  frame_form;
		logic [15:0] offset_delta;
		logic [15:0] count_value;
		logic [7:0]  entry_tag;
		logic [15:0] entry_value;
		logic        entry_list;
		logic [15:0] entry_position;
		logic        frame_last;
		logic        table_last;
	} tok_t;

	function automatic logic [2:0] form_of(input logic [7:0] t);
		logic [2:0] f;
		if (t <= FT_SAME_MAX) f = FF_SAME;
		else if (t <= FT_ONE_STK_MAX) f = FF_ONE_STK;
		else if (t <= FT_RESERVED_MAX) f = FF_RESERVED;
		else if (t == FT_ONE_EXT) f = FF_ONE_EXT;
		else if (t <= FT_CHOP_MAX) f = FF_CHOP;
		else if (t == FT_SAME_EXT) f = FF_SAME_EXT;
		else if (t <= FT_APPEND_MAX) f = FF_APPEND;
		else f = FF_FULL;
		return f;
	endfunction

endpackage

@@ hdl/smfp_step.sv @@
// ----------------------------------------------------------------------------
// smfp_step
// Next parser state and result token for one attribute byte.
// ----------------------------------------------------------------------------
module smfp_step
	import smfp_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] data_byte,
	input  logic       start_req,
	output state_t     nxt,
	output logic       emit,
	output tok_t       tok
);

	logic [15:0] v;
	logic [15:0] frames_dec;
	logic        frames_end;
	logic        fin;
	logic        bad_tag;
	logic        val_tag;

	assign v          = {cur.high_byte, data_byte};
	assign frames_dec = cur.frames_left - 16'd1;
	assign frames_end = (frames_dec == 16'd0);
	assign bad_tag    = (data_byte > VT_MAX);
	assign val_tag    = (data_byte == VT_OBJECT) || (data_byte == VT_UNINIT);

	// next state
	always_comb begin
		logic        is_stk;
		logic [15:0] left_dec;
		nxt      = cur;
		fin      = 1'b0;
		is_stk   = 1'b0;
		left_dec = 16'd0;
		if (start_req) begin
			nxt           = '0;
			nxt.high_byte = data_byte;
			nxt.phase     = PH_CNT_LO;
		end else begin
			case (cur.phase)
				PH_CNT_LO: begin
					nxt.frames_left = v;
					nxt.frame_index = 16'd0;
					nxt.phase       = (v == 16'd0) ? PH_IDLE : PH_TYPE;
				end
				PH_TYPE: begin
					nxt.held_type     = data_byte;
					nxt.held_offset   = 16'd0;
					nxt.locals_left   = 16'd0;
					nxt.stack_left    = 16'd0;
					nxt.list_position = 16'd0;
					if (data_byte <= FT_SAME_MAX ||
						(data_byte > FT_ONE_STK_MAX && data_byte <= FT_RESERVED_MAX)) begin
						fin = 1'b1;
					end else if (data_byte <= FT_ONE_STK_MAX) begin
						nxt.stack_left = 16'd1;
						nxt.phase      = PH_STAG;
					end else begin
						nxt.phase = PH_OFF_HI;
					end
				end
				PH_OFF_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = PH_OFF_LO;
				end
				PH_NLOC_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = PH_NLOC_LO;
				end
				PH_NSTK_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = PH_NSTK_LO;
				end
				PH_LVAL_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = PH_LVAL_LO;
				end
				PH_SVAL_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = PH_SVAL_LO;
				end
				PH_OFF_LO: begin
					nxt.held_offset = v;
					if (cur.held_type == FT_ONE_EXT) begin
						nxt.stack_left    = 16'd1;
						nxt.list_position = 16'd0;
						nxt.phase         = PH_STAG;
					end else if (cur.held_type <= FT_SAME_EXT) begin
						fin = 1'b1;
					end else if (cur.held_type <= FT_APPEND_MAX) begin
						nxt.locals_left   = {8'd0, cur.held_type - FT_SAME_EXT};
						nxt.list_position = 16'd0;
						nxt.phase         = PH_LTAG;
					end else begin
						nxt.phase = PH_NLOC_HI;
					end
				end
				PH_NLOC_LO: begin
					nxt.locals_left = v;
					if (v != 16'd0) begin
						nxt.list_position = 16'd0;
						nxt.phase         = PH_LTAG;
					end else begin
						nxt.phase = PH_NSTK_HI;
					end
				end
				PH_NSTK_LO: begin
					nxt.stack_left = v;
					if (v != 16'd0) begin
						nxt.list_position = 16'd0;
						nxt.phase         = PH_STAG;
					end else begin
						fin = 1'b1;
					end
				end
				PH_LTAG, PH_STAG, PH_LVAL_LO, PH_SVAL_LO: begin
					is_stk = (cur.phase == PH_STAG) || (cur.phase == PH_SVAL_LO);
					if ((cur.phase == PH_LTAG || cur.phase == PH_STAG) && bad_tag) begin
						nxt.phase = PH_IDLE;
					end else if ((cur.phase == PH_LTAG || cur.phase == PH_STAG) && val_tag) begin
						nxt.held_tag = data_byte;
						nxt.phase    = is_stk ? PH_SVAL_HI : PH_LVAL_HI;
					end else begin
						// entry complete
						nxt.list_position = cur.list_position + 16'd1;
						if (is_stk) begin
							left_dec       = cur.stack_left - 16'd1;
							nxt.stack_left = left_dec;
							if (left_dec == 16'd0) fin = 1'b1;
							else nxt.phase = PH_STAG;
						end else begin
							left_dec        = cur.locals_left - 16'd1;
							nxt.locals_left = left_dec;
							if (left_dec != 16'd0) nxt.phase = PH_LTAG;
							else if (cur.held_type == FT_FULL) nxt.phase = PH_NSTK_HI;
							else fin = 1'b1;
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
			if (fin) begin
				nxt.frames_left = frames_dec;
				if (frames_end) begin
					nxt.phase = PH_IDLE;
				end else begin
					nxt.frame_index = cur.frame_index + 16'd1;
					nxt.phase       = PH_TYPE;
				end
			end
		end
	end

	// token
	always_comb begin
		emit                = 1'b0;
		tok                 = '0;
		tok.frame_number    = cur.frame_index;
		tok.frame_type_byte = nxt.held_type;
		tok.frame_form      = form_of(nxt.held_type);
		tok.offset_delta    = nxt.held_offset;
		tok.frame_last      = fin;
		tok.table_last      = fin & frames_end;
		if (!start_req) begin
			case (cur.phase)
				PH_CNT_LO: begin
					emit           = (v == 16'd0);
					tok            = '0;
					tok.token_kind = TK_EMPTY;
					tok.table_last = 1'b1;
				end
				PH_TYPE: begin
					emit           = (data_byte <= FT_RESERVED_MAX);
					tok.token_kind = TK_HEADER;
				end
				PH_OFF_LO: begin
					emit           = 1'b1;
					tok.token_kind = TK_HEADER;
				end
				PH_NLOC_LO: begin
					emit            = 1'b1;
					tok.token_kind  = TK_LCOUNT;
					tok.count_value = v;
				end
				PH_NSTK_LO: begin
					emit            = 1'b1;
					tok.token_kind  = TK_SCOUNT;
					tok.count_value = v;
				end
				PH_LTAG, PH_STAG: begin
					emit               = !val_tag;
					tok.token_kind     = bad_tag ? TK_ERROR : TK_ENTRY;
					tok.entry_tag      = data_byte;
					tok.entry_list     = (cur.phase == PH_STAG);
					tok.entry_position = cur.list_position;
				end
				PH_LVAL_LO, PH_SVAL_LO: begin
					emit               = 1'b1;
					tok.token_kind     = TK_ENTRY;
					tok.entry_tag      = cur.held_tag;
					tok.entry_value    = v;
					tok.entry_list     = (cur.phase == PH_SVAL_LO);
					tok.entry_position = cur.list_position;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

endmodule

@@ hdl/stack_map_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// stack_map_frame_parser_core
// StackMapTable attribute body parser, one byte per beat, one token out.
// ----------------------------------------------------------------------------
// Takes the attribute body one byte per beat (tuser marks the first byte of
// a body) and sends one token per completed element: frame header, locals
// or stack count, verification entry, empty table or bad tag. A byte is
// registered on entry and parsed combinationally between that input
// register and the output register, so the block takes one beat per cycle
// while the output is not stalled, and a token waits in the output register
// until taken. A stall on the output side holds the input side after one
// more byte has been taken.
module stack_map_frame_parser_core
	import smfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tuser,   // start_req
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// frame_number, frame_type_byte, frame_form, offset_delta, count_value,
	// entry_tag, entry_value, entry_list, entry_position, zero fill
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,   // frame_last
	output logic [3:0]   m_axis_tuser    // token_kind, table_last
);

	logic       in_valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       out_valid_q;
	tok_t       tok_q;
	state_t     state_q;
	state_t     nxt;
	logic       emit;
	tok_t       tok;
	logic       adv;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || adv;

	smfp_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.start_req (start_s1),
		.nxt       (nxt),
		.emit      (emit),
		.tok       (tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_axis_tready) in_valid_s1 <= s_axis_tvalid;
			if (adv) out_valid_q <= in_valid_s1 && emit;
			if (adv && in_valid_s1) state_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
		if (adv && in_valid_s1 && emit) tok_q <= tok;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, tok_q.entry_position, tok_q.entry_list, tok_q.entry_value,
		tok_q.entry_tag, tok_q.count_value, tok_q.offset_delta, tok_q.frame_form,
		tok_q.frame_type_byte, tok_q.frame_number};
	assign m_axis_tlast  = tok_q.frame_last;
	assign m_axis_tuser  = {tok_q.table_last, tok_q.token_kind};

	// empty table token always closes the table
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] == TK_EMPTY |-> m_axis_tuser[3])
		else $error("empty table token without table end");

	// table end on a frame token must also end the frame
	a_table_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] && m_axis_tuser[2:0] != TK_EMPTY |-> m_axis_tlast)
		else $error("table end without frame end");

	// error token never closes a frame or the table
	a_error_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] == TK_ERROR |-> !m_axis_tlast && !m_axis_tuser[3])
		else $error("error token marked as last");

	// a start byte restarts the parse without a token
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && adv && start_s1 |=> !m_axis_tvalid && state_q.phase == PH_CNT_LO)
		else $error("start byte produced a token");

endmodule

@@ test/stack_map_frame_parser_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_map_frame_parser_core_tb
// Streams StackMapTable bodies into the parser and checks every token.
// ----------------------------------------------------------------------------
// A short directed sequence is followed by random attribute bodies: mostly
// well-formed tables with random frames and entries, plus stray bytes,
// restarts in mid-parse, bad tags and garbage after a start. A scoreboard
// class tracks the parser state byte by byte, queues the token each
// accepted beat should produce and compares the tokens as they arrive.
// Both sides insert random gaps, and the receiver holds off once for a long
// stretch so that the input side fills up.
// ----------------------------------------------------------------------------
module stack_map_frame_parser_core_tb;
	import smfp_pkg::*;

	class frame_token_board;
		phase_t      phase;
		logic [15:0] frames_left;
		logic [15:0] frame_idx;
		logic [7:0]  ftype;
		logic [15:0] foffset;
		logic [15:0] locals_left;
		logic [15:0] stack_left;
		logic [15:0] list_pos;
		logic [7:0]  held_tag;
		logic [7:0]  high_byte;
		tok_t        cur;
		tok_t        pending_tokens[$];
		int          errors;

		function new();
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			phase = PH_IDLE;
			frames_left = '0;
			frame_idx = '0;
			ftype = '0;
			foffset = '0;
			locals_left = '0;
			stack_left = '0;
			list_pos = '0;
			held_tag = '0;
			high_byte = '0;
		endfunction

		function int pending();
			return pending_tokens.size();
		endfunction

		function logic [2:0] form_code(logic [7:0] t);
			if (t == FT_FULL) return FF_FULL;
			if (t > FT_SAME_EXT) return FF_APPEND;
			if (t == FT_SAME_EXT) return FF_SAME_EXT;
			if (t > FT_ONE_EXT) return FF_CHOP;
			if (t == FT_ONE_EXT) return FF_ONE_EXT;
			if (t > FT_ONE_STK_MAX) return FF_RESERVED;
			if (t > FT_SAME_MAX) return FF_ONE_STK;
			return FF_SAME;
		endfunction

		function void load_frame();
			cur.frame_number = frame_idx;
			cur.frame_type_byte = ftype;
			cur.frame_form = form_code(ftype);
			cur.offset_delta = foffset;
		endfunction

		function void close_frame();
			cur.frame_last = 1'b1;
			frames_left = frames_left - 16'd1;
			if (frames_left == 0) begin
				cur.table_last = 1'b1;
				phase = PH_IDLE;
			end else begin
				frame_idx = frame_idx + 16'd1;
				phase = PH_TYPE;
			end
		endfunction

		function void open_list(bit stk);
			list_pos = '0;
			phase = stk ? PH_STAG : PH_LTAG;
		endfunction

		function void entry_out(bit stk, logic [7:0] tag, logic [15:0] val);
			load_frame();
			cur.token_kind = TK_ENTRY;
			cur.entry_tag = tag;
			cur.entry_value = val;
			cur.entry_list = stk;
			cur.entry_position = list_pos;
			list_pos = list_pos + 16'd1;
			if (stk) begin
				stack_left = stack_left - 16'd1;
				if (stack_left == 0) close_frame();
				else phase = PH_STAG;
			end else begin
				locals_left = locals_left - 16'd1;
				if (locals_left != 0) phase = PH_LTAG;
				else if (ftype == FT_FULL) phase = PH_NSTK_HI;
				else close_frame();
			end
		endfunction

		function bit tag_in(bit stk, logic [7:0] b);
			if (b > VT_MAX) begin
				load_frame();
				cur.token_kind = TK_ERROR;
				cur.entry_tag = b;
				cur.entry_list = stk;
				cur.entry_position = list_pos;
				phase = PH_IDLE;
				return 1'b1;
			end
			if (b == VT_OBJECT || b == VT_UNINIT) begin
				held_tag = b;
				phase = stk ? PH_SVAL_HI : PH_LVAL_HI;
				return 1'b0;
			end
			entry_out(stk, b, 16'd0);
			return 1'b1;
		endfunction

		function void take_byte(logic [7:0] b, logic first);
			logic [15:0] v;
			bit          emit;
			v = {high_byte, b};
			emit = 1'b0;
			cur = '0;
			if (first) begin
				clear_state();
				high_byte = b;
				phase = PH_CNT_LO;
				return;
			end
			case (phase)
				PH_CNT_LO: begin
					frames_left = v;
					frame_idx = '0;
					if (v == 0) begin
						cur.token_kind = TK_EMPTY;
						cur.table_last = 1'b1;
						phase = PH_IDLE;
						emit = 1'b1;
					end else begin
						phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					ftype = b;
					foffset = '0;
					locals_left = '0;
					stack_left = '0;
					list_pos = '0;
					if (b <= FT_SAME_MAX || (b > FT_ONE_STK_MAX && b <= FT_RESERVED_MAX)) begin
						cur.token_kind = TK_HEADER;
						load_frame();
						close_frame();
						emit = 1'b1;
					end else if (b <= FT_ONE_STK_MAX) begin
						cur.token_kind = TK_HEADER;
						load_frame();
						stack_left = 16'd1;
						open_list(1'b1);
						emit = 1'b1;
					end else begin
						phase = PH_OFF_HI;
					end
				end
				PH_OFF_HI, PH_NLOC_HI, PH_NSTK_HI, PH_LVAL_HI, PH_SVAL_HI: begin
					high_byte = b;
					phase = phase_t'(phase + 4'd1);
				end
				PH_OFF_LO: begin
					foffset = v;
					cur.token_kind = TK_HEADER;
					load_frame();
					emit = 1'b1;
					if (ftype == FT_ONE_EXT) begin
						stack_left = 16'd1;
						open_list(1'b1);
					end else if (ftype <= FT_SAME_EXT) begin
						close_frame();
					end else if (ftype <= FT_APPEND_MAX) begin
						locals_left = 16'(ftype - FT_SAME_EXT);
						open_list(1'b0);
					end else begin
						phase = PH_NLOC_HI;
					end
				end
				PH_NLOC_LO: begin
					load_frame();
					cur.token_kind = TK_LCOUNT;
					cur.count_value = v;
					locals_left = v;
					emit = 1'b1;
					if (v != 0) open_list(1'b0);
					else phase = PH_NSTK_HI;
				end
				PH_NSTK_LO: begin
					load_frame();
					cur.token_kind = TK_SCOUNT;
					cur.count_value = v;
					stack_left = v;
					emit = 1'b1;
					if (v != 0) open_list(1'b1);
					else close_frame();
				end
				PH_LTAG: emit = tag_in(1'b0, b);
				PH_STAG: emit = tag_in(1'b1, b);
				PH_LVAL_LO: begin
					entry_out(1'b0, held_tag, v);
					emit = 1'b1;
				end
				PH_SVAL_LO: begin
					entry_out(1'b1, held_tag, v);
					emit = 1'b1;
				end
				default: ;
			endcase
			if (emit) pending_tokens.insert(pending_tokens.size(), cur);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_token(tok_t got);
			tok_t want;
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected token, kind %0d frame %0d", $time,
						got.token_kind, got.frame_number);
				return;
			end
			want = pending_tokens.pop_front();
			compare_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
			compare_field("frame_number", want.frame_number, got.frame_number);
			compare_field("frame_type_byte", 16'(want.frame_type_byte),
				16'(got.frame_type_byte));
			compare_field("frame_form", 16'(want.frame_form), 16'(got.frame_form));
			compare_field("offset_delta", want.offset_delta, got.offset_delta);
			compare_field("count_value", want.count_value, got.count_value);
			compare_field("entry_tag", 16'(want.entry_tag), 16'(got.entry_tag));
			compare_field("entry_value", want.entry_value, got.entry_value);
			compare_field("entry_list", 16'(want.entry_list), 16'(got.entry_list));
			compare_field("entry_position", want.entry_position, got.entry_position);
			compare_field("frame_last", 16'(want.frame_last), 16'(got.frame_last));
			compare_field("table_last", 16'(want.table_last), 16'(got.table_last));
		endfunction
	endclass

	typedef struct packed {
		logic       first;
		logic [7:0] data;
	} beat_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic [3:0]   m_axis_tuser;

	frame_token_board board = new();
	beat_t            plan[$];
	int               planned = 0;
	int               sent = 0;
	bit               src_calm = 1'b0;

	stack_map_frame_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("[stack_map_frame_parser_core] ERROR");
		$finish;
	end

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_beat(logic first, logic [7:0] d);
		beat_t nb;
		nb.first = first;
		nb.data = d;
		plan.insert(plan.size(), nb);
	endfunction

	function automatic void plan_byte(logic first, logic [7:0] d);
		add_beat(first, d);
		planned++;
	endfunction

	function automatic void plan_word(logic [15:0] w);
		plan_byte(1'b0, w[15:8]);
		plan_byte(1'b0, w[7:0]);
	endfunction

	function automatic void plan_entry();
		logic [7:0] tag;
		if ($urandom_range(0, 99) < 2) tag = 8'($urandom_range(VT_MAX + 1, 8'hFF));
		else tag = 8'($urandom_range(0, VT_MAX));
		plan_byte(1'b0, tag);
		if (tag == VT_OBJECT || tag == VT_UNINIT) plan_word(16'($urandom));
	endfunction

	function automatic void plan_frame();
		int         r;
		int         n;
		logic [7:0] t;
		r = $urandom_range(0, 99);
		if (r < 15) t = 8'($urandom_range(0, FT_SAME_MAX));
		else if (r < 30) t = 8'($urandom_range(FT_SAME_MAX + 1, FT_ONE_STK_MAX));
		else if (r < 38) t = 8'($urandom_range(FT_ONE_STK_MAX + 1, FT_RESERVED_MAX));
		else if (r < 46) t = FT_ONE_EXT;
		else if (r < 54) t = 8'($urandom_range(FT_ONE_EXT + 1, FT_CHOP_MAX));
		else if (r < 62) t = FT_SAME_EXT;
		else if (r < 80) t = 8'($urandom_range(FT_SAME_EXT + 1, FT_APPEND_MAX));
		else t = FT_FULL;
		plan_byte(1'b0, t);
		if (t <= FT_RESERVED_MAX) begin
			if (t > FT_SAME_MAX && t <= FT_ONE_STK_MAX) plan_entry();
			return;
		end
		plan_word(16'($urandom));
		if (t == FT_ONE_EXT) begin
			plan_entry();
		end else if (t > FT_SAME_EXT && t < FT_FULL) begin
			repeat (t - FT_SAME_EXT) plan_entry();
		end else if (t == FT_FULL) begin
			n = $urandom_range(0, 3);
			plan_word(16'(n));
			repeat (n) plan_entry();
			n = $urandom_range(0, 3);
			plan_word(16'(n));
			repeat (n) plan_entry();
		end
	endfunction

	function automatic void plan_stack_map();
		int          mark;
		int          r;
		int          n;
		int          cut;
		logic [15:0] count;
		// stray bytes ahead of the start byte
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 4)) add_beat(1'b0, 8'($urandom));
		mark = plan.size();
		r = $urandom_range(0, 99);
		if (r < 5) begin
			plan_byte(1'b1, 8'($urandom));
			repeat ($urandom_range(2, 20)) plan_byte(1'b0, 8'($urandom));
			return;
		end
		if (r < 10) count = '0;
		else if (r < 14) count = 16'($urandom);
		else count = 16'($urandom_range(1, 6));
		plan_byte(1'b1, count[15:8]);
		plan_byte(1'b0, count[7:0]);
		n = (count > 6) ? $urandom_range(1, 6) : int'(count);
		repeat (n) plan_frame();
		// cut short, the next start aborts it
		if ($urandom_range(0, 9) == 0 && plan.size() - mark > 4) begin
			cut = $urandom_range(1, 3);
			repeat (cut) void'(plan.pop_back());
			planned -= cut;
		end
	endfunction

	task automatic send_plan();
		beat_t b;
		int    gap;
		while (plan.size() != 0) begin
			b = plan.pop_front();
			if (sent % 50 == 0) src_calm = ($urandom_range(0, 3) == 0);
			gap = pick_gap(src_calm);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= b.data;
			s_axis_tuser <= b.first;
			do @(posedge clk); while (!s_axis_tready);
			board.take_byte(b.data, b.first);
			sent++;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	// receiver side
	initial begin : token_sink
		int   hold;
		int   seen;
		int   cycles;
		bit   calm;
		tok_t got;
		hold = 0;
		seen = 0;
		cycles = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			cycles++;
			if (cycles % 50 == 0) calm = ($urandom_range(0, 3) == 0);
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < 3) begin
				m_axis_tready <= 1'b0;
				hold = $urandom_range(8, 40) - 1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) < 75);
			end
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.frame_number = m_axis_tdata[15:0];
				got.frame_type_byte = m_axis_tdata[23:16];
				got.frame_form = m_axis_tdata[26:24];
				got.offset_delta = m_axis_tdata[42:27];
				got.count_value = m_axis_tdata[58:43];
				got.entry_tag = m_axis_tdata[66:59];
				got.entry_value = m_axis_tdata[82:67];
				got.entry_list = m_axis_tdata[83];
				got.entry_position = m_axis_tdata[99:84];
				got.frame_last = m_axis_tlast;
				got.token_kind = m_axis_tuser[2:0];
				got.table_last = m_axis_tuser[3];
				board.check_token(got);
				seen++;
				// long hold-off so the input side backs up
				if (seen == 120) hold = 300;
			end
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray byte before any start, then an empty table
		add_beat(1'b0, 8'hAA);
		plan_byte(1'b1, 8'h00);
		plan_byte(1'b0, 8'h00);
		// four frames: same, one-stack with uninit entry, reserved, full with no lists
		plan_byte(1'b1, 8'h00);
		plan_byte(1'b0, 8'h04);
		plan_byte(1'b0, FT_SAME_MAX);
		plan_byte(1'b0, FT_SAME_MAX + 8'd1);
		plan_byte(1'b0, VT_UNINIT);
		plan_word(16'hFFFF);
		plan_byte(1'b0, FT_ONE_STK_MAX + 8'd1);
		plan_byte(1'b0, FT_FULL);
		plan_word(16'h0000);
		plan_word(16'h0000);
		plan_word(16'h0000);
		// huge count, restart in mid-table, then a bad tag and an ignored byte
		plan_byte(1'b1, 8'hFF);
		plan_byte(1'b0, 8'hFF);
		plan_byte(1'b0, FT_SAME_EXT);
		plan_word(16'h1234);
		plan_byte(1'b1, 8'h00);
		plan_byte(1'b0, 8'h01);
		plan_byte(1'b0, FT_APPEND_MAX - 8'd1);
		plan_word(16'h0000);
		plan_byte(1'b0, VT_MAX + 8'd1);
		add_beat(1'b0, 8'h55);
		send_plan();
		wait_drained();

		planned = 0;
		while (planned < 700) plan_stack_map();
		send_plan();
		wait_drained();

		planned = 0;
		while (planned < 700) plan_stack_map();
		send_plan();
		wait_drained();

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("[stack_map_frame_parser_core] OK");
		else
			$display("[stack_map_frame_parser_core] ERROR");
		$finish;
	end

endmodule
